/* src/mau_pkg.sv */
// Package for the modular arithmetic unit: operation codes, sequencer states
// and reduction targets. No dependencies.
`default_nettype none
package mau_pkg;

  localparam int unsigned ResW = 31;
  localparam int unsigned RawW = 64;
  localparam int unsigned ExpW = 63;
  localparam logic [ResW-1:0] ModulusReset = 31'd998244353;

  typedef enum logic [2:0] {
    KIND_REDUCE = 3'd0,
    KIND_ADD    = 3'd1,
    KIND_SUB    = 3'd2,
    KIND_MUL    = 3'd3,
    KIND_DIV    = 3'd4,
    KIND_POW    = 3'd5,
    KIND_INV    = 3'd6,
    KIND_NEG    = 3'd7
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RGO,
    ST_RWAIT,
    ST_DISPATCH,
    ST_PSTEP,
    ST_MUL,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    TGT_A,
    TGT_B,
    TGT_RAW,
    TGT_ACC,
    TGT_X,
    TGT_RES
  } tgt_e;

endpackage
`default_nettype wire

/* src/mau_modred.sv */
// Bit-serial remainder unit: 64-bit value modulo a 31-bit modulus,
// one dividend bit per cycle. Depends on mau_pkg.
`default_nettype none
module mau_modred (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [mau_pkg::RawW-1:0]   value_i,
  input  wire logic [mau_pkg::ResW-1:0]   modulus_i,
  output logic                            done_o,
  output logic [mau_pkg::ResW-1:0]        rem_o
);
  import mau_pkg::*;

  logic [RawW-1:0] val_q;
  logic [ResW-1:0] rem_q;
  logic [5:0]      cnt_q;
  logic            run_q;
  logic            done_q;
  logic [ResW:0]   trial;
  logic [ResW:0]   diff;
  logic            ge;

  assign trial = {rem_q, val_q[RawW-1]};
  assign diff  = trial - {1'b0, modulus_i};
  assign ge    = trial >= {1'b0, modulus_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q <= value_i;
      rem_q <= '0;
    end else if (run_q) begin
      val_q <= {val_q[RawW-2:0], 1'b0};
      rem_q <= ge ? diff[ResW-1:0] : trial[ResW-1:0];
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

/* src/modular_arithmetic_unit.sv */
// Top level of the modular arithmetic unit: modulus register, sequencer,
// multiplier and square-and-multiply loop. Depends on mau_pkg, mau_modred.
//
// Usage: write the prime modulus through cfg_we_i/cfg_data_i while idle
// (reset value 998244353). Present an operation on kind_i and its operands,
// raise start; the item transfers at a clock edge with start high and busy
// low. busy stays high until the result is delivered. The result appears on
// result_o for exactly one cycle with result_valid_o high; the receiver
// cannot stall it.
// Sequence: every remainder pass goes through the bit-serial reduction
// unit. Operands are reduced first. Add, sub and negate finish after the
// operand reductions, reduce and mul after one more pass. Pow, divide and
// inverse run square-and-multiply, one modular multiply per exponent bit
// plus one per set bit, exponents up to 63 bits. Divide and inverse use
// the 31-bit exponent modulus - 2. A new item is accepted only after the
// previous result is delivered.
// Reset clears the sequencer and loads the default modulus.
`default_nettype none
module modular_arithmetic_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [mau_pkg::ResW-1:0]    cfg_data_i,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [2:0]                  kind_i,
  input  wire logic [mau_pkg::ResW-1:0]    operand_a_i,
  input  wire logic [mau_pkg::ResW-1:0]    operand_b_i,
  input  wire logic [mau_pkg::ExpW-1:0]    exponent_i,
  input  wire logic signed [mau_pkg::RawW-1:0] raw_value_i,
  output logic                             result_valid_o,
  output logic [mau_pkg::ResW-1:0]         result_o
);
  import mau_pkg::*;

  state_e          state_q, state_d;
  tgt_e            tgt_q;
  kind_e           kind_q;
  logic [ResW-1:0] modulus_q;
  logic [ResW-1:0] a_q, b_q, acc_q, x_q, mx_q, my_q, res_q;
  logic [ExpW-1:0] e_q;
  logic [RawW-1:0] raw_q, red_in_q, mag;
  logic            red_start, red_done;
  logic [ResW-1:0] red_rem;
  logic [ResW:0]   sum, sum_m, sub_w;
  logic [2*ResW-1:0] prod;
  logic            accept;

  assign accept = start && !busy;
  assign mag    = raw_q[RawW-1] ? (~raw_q + 64'd1) : raw_q;
  assign sum    = {1'b0, a_q} + {1'b0, b_q};
  assign sum_m  = sum - {1'b0, modulus_q};
  assign sub_w  = {1'b0, a_q} + {1'b0, modulus_q} - {1'b0, b_q};
  assign prod   = mx_q * my_q;

  mau_modred u_modred (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (red_start),
    .value_i   (red_in_q),
    .modulus_i (modulus_q),
    .done_o    (red_done),
    .rem_o     (red_rem)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (start) state_d = (modulus_q < 31'd2) ? ST_DONE : ST_RGO;
      ST_RGO:      state_d = ST_RWAIT;
      ST_RWAIT: begin
        if (red_done) begin
          unique case (tgt_q)
            TGT_A:           state_d = ST_RGO;
            TGT_B:           state_d = ST_DISPATCH;
            TGT_ACC:         state_d = ST_MUL;
            TGT_X:           state_d = ST_PSTEP;
            TGT_RAW, TGT_RES: state_d = ST_DONE;
            default:         state_d = ST_DONE;
          endcase
        end
      end
      ST_DISPATCH: begin
        unique case (kind_q)
          KIND_REDUCE:                state_d = ST_RGO;
          KIND_MUL:                   state_d = ST_MUL;
          KIND_DIV, KIND_POW:         state_d = ST_PSTEP;
          KIND_INV:                   state_d = (a_q <= 31'd1) ? ST_DONE : ST_PSTEP;
          default:                    state_d = ST_DONE;
        endcase
      end
      ST_PSTEP: begin
        if (e_q == '0 && kind_q != KIND_DIV) state_d = ST_DONE;
        else                                 state_d = ST_MUL;
      end
      ST_MUL:  state_d = ST_RGO;
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy           = state_q != ST_IDLE;
  assign red_start      = state_q == ST_RGO;
  assign result_valid_o = state_q == ST_DONE;
  assign result_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      modulus_q <= ModulusReset;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) modulus_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          kind_q   <= kind_e'(kind_i);
          b_q      <= operand_b_i;
          e_q      <= exponent_i;
          raw_q    <= raw_value_i;
          red_in_q <= {33'd0, operand_a_i};
          tgt_q    <= TGT_A;
          res_q    <= '0;
        end
      end
      ST_RWAIT: begin
        if (red_done) begin
          unique case (tgt_q)
            TGT_A: begin
              a_q      <= red_rem;
              red_in_q <= {33'd0, b_q};
              tgt_q    <= TGT_B;
            end
            TGT_B: b_q <= red_rem;
            TGT_RAW: res_q <= (raw_q[RawW-1] && red_rem != '0) ? modulus_q - red_rem
                                                               : red_rem;
            TGT_ACC: begin
              acc_q <= red_rem;
              mx_q  <= x_q;
              my_q  <= x_q;
              tgt_q <= TGT_X;
            end
            TGT_X: begin
              x_q <= red_rem;
              e_q <= e_q >> 1;
            end
            default: res_q <= red_rem;
          endcase
        end
      end
      ST_DISPATCH: begin
        acc_q <= 31'd1;
        unique case (kind_q)
          KIND_REDUCE: begin
            red_in_q <= mag;
            tgt_q    <= TGT_RAW;
          end
          KIND_ADD: res_q <= (sum >= {1'b0, modulus_q}) ? sum_m[ResW-1:0] : sum[ResW-1:0];
          KIND_SUB: res_q <= (a_q >= b_q) ? a_q - b_q : sub_w[ResW-1:0];
          KIND_MUL: begin
            mx_q  <= a_q;
            my_q  <= b_q;
            tgt_q <= TGT_RES;
          end
          KIND_DIV: begin
            x_q <= b_q;
            e_q <= {32'd0, modulus_q - 31'd2};
          end
          KIND_POW: x_q <= a_q;
          KIND_INV: begin
            x_q   <= a_q;
            e_q   <= {32'd0, modulus_q - 31'd2};
            res_q <= 31'd1;
          end
          default: res_q <= (a_q == '0) ? '0 : modulus_q - a_q;
        endcase
      end
      ST_PSTEP: begin
        if (e_q == '0) begin
          res_q <= acc_q;
          mx_q  <= acc_q;
          my_q  <= a_q;
          tgt_q <= TGT_RES;
        end else if (e_q[0]) begin
          mx_q  <= acc_q;
          my_q  <= x_q;
          tgt_q <= TGT_ACC;
        end else begin
          mx_q  <= x_q;
          my_q  <= x_q;
          tgt_q <= TGT_X;
        end
      end
      ST_MUL:  red_in_q <= {2'd0, prod};
      default: ;
    endcase
  end

endmodule
`default_nettype wire
